FILE: hdl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared constants for the timed dispatch queue: default sizes, opcodes and
// result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_TIME_BITS   = 32;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned JOB_W  = 8;
  localparam int unsigned IO_TIME_W = 32;
  localparam int unsigned OCC_W  = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_SUBMIT = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] K_ACCEPTED   = 3'd0;
  localparam logic [KIND_W-1:0] K_DISPATCHED = 3'd1;
  localparam logic [KIND_W-1:0] K_REMOVED    = 3'd2;
  localparam logic [KIND_W-1:0] K_NOTHING    = 3'd3;
  localparam logic [KIND_W-1:0] K_FULL       = 3'd4;
  localparam logic [KIND_W-1:0] K_EMPTY      = 3'd5;

endpackage

`default_nettype wire

FILE: hdl/timed_dispatch_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_dispatch_queue_unit
// Job queue kept sorted by due time (submit time + delay, saturating). Ticks
// dispatch every due head job, remove drops the head.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | transaction
//  --------+-----------------------------------------+-----+---------------------
//  in      | in_valid/in_ready, op, now, delay, id   | in  | one command
//  out     | out_valid/out_ready, kind, job, due,    | out | one result; a tick
//          | occupancy, last                         |     | may give several
//
// Steps per command (ring buffer in one RAM, registered read):
//   submit reads and compares entries from the tail down (the later ones, each
//   shifted up one slot, plus the one it lands behind); tick examines each head
//   in turn; remove reads the head; full submit or empty remove skips the RAM.
// Reset: rst_n (sync) empties the queue; RAM contents are not cleared.
// Stalls: one command at a time; out_ready low holds the output register and dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_dispatch_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = tdq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned TIME_BITS   = tdq_pkg::DEF_TIME_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tdq_pkg::OP_W-1:0]      in_op,
  input  wire logic [tdq_pkg::IO_TIME_W-1:0] in_now,
  input  wire logic [tdq_pkg::IO_TIME_W-1:0] in_delay,
  input  wire logic [tdq_pkg::JOB_W-1:0]     in_job_id,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tdq_pkg::KIND_W-1:0]    out_kind,
  output logic      [tdq_pkg::JOB_W-1:0]     out_job,
  output logic      [tdq_pkg::IO_TIME_W-1:0] out_due_time,
  output logic      [tdq_pkg::OCC_W-1:0]     out_occupancy,
  output logic                               out_last
);

  import tdq_pkg::*;

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DATA_W = TIME_BITS + JOB_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   RING_SZ  = (IDX_W+1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_OUT     = 9'b000000010,
    S_INS_RD  = 9'b000000100,
    S_INS_CMP = 9'b000001000,
    S_INS_PUT = 9'b000010000,
    S_TK_RD   = 9'b000100000,
    S_TK_CMP  = 9'b001000000,
    S_RM_RD   = 9'b010000000,
    S_RM_CMP  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;      // logical slot under compare
  logic [IDX_W-1:0]   put_r, put_nxt;      // logical slot for the new entry
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic               held_r, held_nxt;    // a dispatched job is pending

  // pending result
  logic [KIND_W-1:0]    res_kind_r, res_kind_nxt;
  logic [JOB_W-1:0]     res_job_r, res_job_nxt;
  logic [TIME_BITS-1:0] res_due_r, res_due_nxt;
  logic [CNT_W-1:0]     res_occ_r, res_occ_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [JOB_W-1:0]     out_job_r, out_job_nxt;
  logic [TIME_BITS-1:0] out_due_r, out_due_nxt;
  logic [CNT_W-1:0]     out_occ_r, out_occ_nxt;
  logic                 out_last_r, out_last_nxt;

  // RAM
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data_r;
  logic [TIME_BITS-1:0] rd_due;
  logic [JOB_W-1:0]     rd_job;

  logic                 out_free;
  logic                 head_due;
  logic [TIME_BITS:0]   due_sum;
  logic [TIME_BITS-1:0] due_sat;
  logic [IDX_W-1:0]     head_inc;

  // logical slot -> RAM address (ring around head)
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [IDX_W-1:0] l);
    logic [IDX_W:0] s;
    s = {1'b0, hd} + {1'b0, l};
    if (s >= RING_SZ) begin
      s = s - RING_SZ;
    end
    return s[IDX_W-1:0];
  endfunction

  tdq_entry_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign rd_due = rd_data_r[DATA_W-1:JOB_W];
  assign rd_job = rd_data_r[JOB_W-1:0];

  // saturating due time
  assign due_sum = {1'b0, TIME_BITS'(in_now)} + {1'b0, TIME_BITS'(in_delay)};
  assign due_sat = due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign head_due = (count_r != '0) && (rd_due <= tick_r);
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;

  assign in_ready = (state_r == S_IDLE);

  // RAM addressing
  always_comb begin
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = phys(head_r, put_r);
    wr_data = {res_due_r, res_job_r};
    unique case (state_r)
      S_INS_RD: rd_addr = phys(head_r, idx_r);
      S_INS_CMP: begin
        // later entry moves up one slot
        if (rd_due > res_due_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, idx_r + 1'b1);
          wr_data = rd_data_r;
        end
      end
      S_INS_PUT: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    put_nxt      = put_r;
    tick_nxt     = tick_r;
    held_nxt     = held_r;
    res_kind_nxt = res_kind_r;
    res_job_nxt  = res_job_r;
    res_due_nxt  = res_due_r;
    res_occ_nxt  = res_occ_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_job_nxt   = out_job_r;
    out_due_nxt   = out_due_r;
    out_occ_nxt   = out_occ_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_SUBMIT: begin
              res_job_nxt = in_job_id;
              res_due_nxt = due_sat;
              if (count_r == CNT_FULL) begin
                res_kind_nxt = K_FULL;
                res_occ_nxt  = count_r;
                state_nxt    = S_OUT;
              end else if (count_r == '0) begin
                res_kind_nxt = K_ACCEPTED;
                put_nxt      = '0;
                state_nxt    = S_INS_PUT;
              end else begin
                res_kind_nxt = K_ACCEPTED;
                idx_nxt      = IDX_W'(count_r - 1'b1);
                state_nxt    = S_INS_RD;
              end
            end
            OP_TICK: begin
              tick_nxt  = TIME_BITS'(in_now);
              held_nxt  = 1'b0;
              state_nxt = S_TK_RD;
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_kind_nxt = K_EMPTY;
                res_job_nxt  = '0;
                res_due_nxt  = '0;
                res_occ_nxt  = '0;
                state_nxt    = S_OUT;
              end else begin
                state_nxt = S_RM_RD;
              end
            end
            default: ;  // unused opcode: dropped, no result
          endcase
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_job_nxt   = res_job_r;
          out_due_nxt   = res_due_r;
          out_occ_nxt   = res_occ_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // insertion: walk down from the tail, shifting later entries up;
      // equal due times stay ahead of the new entry
      S_INS_RD: state_nxt = S_INS_CMP;

      S_INS_CMP: begin
        if (rd_due > res_due_r) begin
          if (idx_r == '0) begin
            put_nxt   = '0;
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_INS_RD;
          end
        end else begin
          put_nxt   = idx_r + 1'b1;
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        count_nxt   = count_r + 1'b1;
        res_occ_nxt = count_r + 1'b1;
        state_nxt   = S_OUT;
      end

      // dispatch: hold each due job until the next head is checked, so
      // that last can be set on the final one
      S_TK_RD: state_nxt = S_TK_CMP;

      S_TK_CMP: begin
        if (!held_r) begin
          if (head_due) begin
            res_kind_nxt = K_DISPATCHED;
            res_job_nxt  = rd_job;
            res_due_nxt  = rd_due;
            res_occ_nxt  = count_r - 1'b1;
            head_nxt     = head_inc;
            count_nxt    = count_r - 1'b1;
            held_nxt     = 1'b1;
            state_nxt    = S_TK_RD;
          end else begin
            res_kind_nxt = K_NOTHING;
            res_job_nxt  = '0;
            res_due_nxt  = '0;
            res_occ_nxt  = count_r;
            state_nxt    = S_OUT;
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_job_nxt   = res_job_r;
          out_due_nxt   = res_due_r;
          out_occ_nxt   = res_occ_r;
          out_last_nxt  = !head_due;
          if (head_due) begin
            res_job_nxt = rd_job;
            res_due_nxt = rd_due;
            res_occ_nxt = count_r - 1'b1;
            head_nxt    = head_inc;
            count_nxt   = count_r - 1'b1;
            state_nxt   = S_TK_RD;
          end else begin
            held_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      S_RM_RD: state_nxt = S_RM_CMP;

      S_RM_CMP: begin
        res_kind_nxt = K_REMOVED;
        res_job_nxt  = rd_job;
        res_due_nxt  = rd_due;
        res_occ_nxt  = count_r - 1'b1;
        head_nxt     = head_inc;
        count_nxt    = count_r - 1'b1;
        state_nxt    = S_OUT;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    put_r      <= put_nxt;
    tick_r     <= tick_nxt;
    res_kind_r <= res_kind_nxt;
    res_job_r  <= res_job_nxt;
    res_due_r  <= res_due_nxt;
    res_occ_r  <= res_occ_nxt;
    out_kind_r <= out_kind_nxt;
    out_job_r  <= out_job_nxt;
    out_due_r  <= out_due_nxt;
    out_occ_r  <= out_occ_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_job       = out_job_r;
  assign out_due_time  = IO_TIME_W'(out_due_r);
  assign out_occupancy = OCC_W'(out_occ_r);
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/tdq_entry_ram.sv
// ----------------------------------------------------------------------------
// tdq_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_entry_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 40,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire
